FILE: rtl/memory_admission_controller_top_assert.svh
// Assertion macros for the port checker of the admission controller.
`ifndef MEMORY_ADMISSION_CONTROLLER_TOP_ASSERT_SVH
`define MEMORY_ADMISSION_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define MAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define MAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mac_pkg.sv
// Shared types, codes and default sizes of the memory admission controller.
package mac_pkg;

	localparam int OWNER_SLOTS_DEF = 256;
	localparam int BYTE_BITS_DEF   = 48;

	localparam int OWNER_W = 8;
	localparam int BYTES_W = 48;
	localparam int TOTAL_W = 56;

	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_ADMIT    = 2'd0,
		ST_REJECT   = 2'd1,
		ST_RELEASED = 2'd2,
		ST_ABSENT   = 2'd3
	} status_t;

	typedef struct packed {
		logic               op;
		logic [OWNER_W-1:0] owner_id;
		logic [BYTES_W-1:0] request_bytes;
		logic [BYTES_W-1:0] free_bytes;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [BYTES_W-1:0] allocatable;
		logic [TOTAL_W-1:0] reserved_total;
	} out_item_t;

endpackage

FILE: rtl/mac_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module mac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/memory_admission_controller_top.sv
// Top level of the memory admission controller: slot memories, sequencer and result register.
//
// Usage. Requests arrive on the input channel (in_valid, in_stall, in_data). A reserve
// asks for request_bytes for one owner given the currently available bytes; a release
// drops the owner's reservation. Every transaction yields exactly one result on the
// output channel (out_valid, out_stall, out_data) carrying a status, the bytes the owner
// could have been granted and the new sum of all reservations. The user must write the
// safety margin through cfg_we and cfg_wdata only while the block is idle; the block
// itself does not enforce this. Sequencing: an accepted request passes through S_READ,
// S_CALC and S_DONE, and its result is registered as it leaves S_DONE; no new request is
// taken before then. This is one read-modify-write of the owner's slot in the synchronous
// slot memories: read at accept, compare and subtract on the 56-bit total, write-back.
// Reset: the whole valid map is swept clear one slot per cycle once arst_n rises; in_stall
// stays high during the sweep. Configuration writes are taken during the sweep as usual.
// Stalls: a finished result waits in the output register while out_stall is high. The
// next request is still accepted and worked on, and it only holds in its last cycle until
// the output register is free.
module memory_admission_controller_top #(
	parameter int OWNER_SLOTS = mac_pkg::OWNER_SLOTS_DEF,
	parameter int BYTE_BITS   = mac_pkg::BYTE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mac_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mac_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [mac_pkg::BYTES_W-1:0] cfg_wdata
);

	localparam int BYTES_W = mac_pkg::BYTES_W;
	localparam int TOTAL_W = mac_pkg::TOTAL_W;
	localparam int IDX_W   = $clog2(OWNER_SLOTS);
	// Width that holds both an owner id and the slot count, for the range check.
	localparam int EXT_W   = ((IDX_W > mac_pkg::OWNER_W) ? IDX_W : mac_pkg::OWNER_W) + 1;
	// Only the low BYTE_BITS bits of the 48-bit byte fields take part.
	localparam int SLOT_W  = (BYTE_BITS < BYTES_W) ? BYTE_BITS : BYTES_W;
	localparam logic [BYTES_W-1:0] BYTE_MASK = BYTES_W'({SLOT_W{1'b1}});
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(OWNER_SLOTS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CALC,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     clr_idx_q;
	logic [BYTES_W-1:0]   margin_q;
	logic [TOTAL_W-1:0]   total_q;

	// Request captured at accept time.
	logic                 op_q;
	logic                 in_range_q;
	logic [IDX_W-1:0]     addr_q;
	logic [BYTES_W-1:0]   req_q;
	logic [BYTES_W-1:0]   avail_q;

	// Intermediate results of the read-modify-write.
	logic                 valid_q;
	logic [TOTAL_W-1:0]   others_q;
	logic                 margin_ge_q;
	logic [BYTES_W-1:0]   avail_m_q;
	logic [BYTES_W-1:0]   alloc_q;

	logic                 out_valid_q;
	mac_pkg::out_item_t   out_data_q;

	logic                 accept;
	logic                 fire;
	logic [EXT_W-1:0]     id_ext;
	logic [BYTES_W-1:0]   margin_m;
	logic [TOTAL_W-1:0]   own;
	logic                 admit;
	logic                 rel_ok;

	logic                 vld_we;
	logic [IDX_W-1:0]     vld_waddr;
	logic                 vld_wdata;
	logic                 vld_rdata;
	logic                 bytes_we;
	logic [SLOT_W-1:0]    bytes_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign id_ext   = EXT_W'(in_data.owner_id);
	assign margin_m = margin_q & BYTE_MASK;
	assign own      = vld_rdata ? TOTAL_W'(bytes_rdata) : '0;

	// The result can only be loaded once the previous one has left or is leaving.
	assign fire   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign admit  = in_range_q && (op_q == mac_pkg::OP_RESERVE) && (req_q <= alloc_q);
	assign rel_ok = in_range_q && (op_q == mac_pkg::OP_RELEASE) && valid_q;

	// The valid map is written by the reset sweep and by admitted or released slots.
	always_comb begin
		vld_we    = 1'b0;
		vld_waddr = addr_q;
		vld_wdata = 1'b0;
		if (state_q == S_CLEAR) begin
			vld_we    = 1'b1;
			vld_waddr = clr_idx_q;
		end else if (fire && (admit || rel_ok)) begin
			vld_we    = 1'b1;
			vld_wdata = admit;
		end
	end

	assign bytes_we = fire && admit;

	mac_ram #(
		.WIDTH (1),
		.DEPTH (OWNER_SLOTS)
	) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.re    (accept),
		.raddr (id_ext[IDX_W-1:0]),
		.rdata (vld_rdata)
	);

	mac_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (OWNER_SLOTS)
	) u_bytes_ram (
		.clk   (clk),
		.we    (bytes_we),
		.waddr (addr_q),
		.wdata (req_q[SLOT_W-1:0]),
		.re    (accept),
		.raddr (id_ext[IDX_W-1:0]),
		.rdata (bytes_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			total_q     <= '0;
			op_q        <= mac_pkg::OP_RESERVE;
			in_range_q  <= 1'b0;
			addr_q      <= '0;
			req_q       <= '0;
			avail_q     <= '0;
			valid_q     <= 1'b0;
			others_q    <= '0;
			margin_ge_q <= 1'b0;
			avail_m_q   <= '0;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// A new result is loaded as the old one leaves, so valid only drops when
			// the output register empties with nothing to replace it.
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q       <= in_data.op;
						in_range_q <= (id_ext < EXT_W'(OWNER_SLOTS));
						addr_q     <= id_ext[IDX_W-1:0];
						req_q      <= in_data.request_bytes & BYTE_MASK;
						avail_q    <= in_data.free_bytes & BYTE_MASK;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					valid_q     <= vld_rdata;
					others_q    <= total_q - own;
					margin_ge_q <= (margin_m >= avail_q);
					avail_m_q   <= avail_q - margin_m;
					state_q     <= S_CALC;
				end
				S_CALC: begin
					// Nothing is allocatable on a release, for an owner without a slot,
					// or once the margin plus the other owners use up the available bytes.
					if (!in_range_q || (op_q == mac_pkg::OP_RELEASE) || margin_ge_q ||
						(others_q >= TOTAL_W'(avail_m_q))) begin
						alloc_q <= '0;
					end else begin
						alloc_q <= avail_m_q - others_q[BYTES_W-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (fire) begin
						out_data_q.allocatable <= alloc_q;
						if (op_q == mac_pkg::OP_RELEASE) begin
							if (rel_ok) begin
								total_q                   <= others_q;
								out_data_q.status         <= mac_pkg::ST_RELEASED;
								out_data_q.reserved_total <= others_q;
							end else begin
								out_data_q.status         <= mac_pkg::ST_ABSENT;
								out_data_q.reserved_total <= total_q;
							end
						end else if (admit) begin
							total_q                   <= others_q + TOTAL_W'(req_q);
							out_data_q.status         <= mac_pkg::ST_ADMIT;
							out_data_q.reserved_total <= others_q + TOTAL_W'(req_q);
						end else begin
							out_data_q.status         <= mac_pkg::ST_REJECT;
							out_data_q.reserved_total <= total_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/mac_checker.sv
// Port-level assertions of the memory admission controller and their binding.
`include "memory_admission_controller_top_assert.svh"

module mac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input mac_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input mac_pkg::out_item_t out_data
);

	logic in_fire;
	logic is_release;

	assign in_fire    = in_valid && !in_stall;
	assign is_release = (out_data.status == mac_pkg::ST_RELEASED) ||
		(out_data.status == mac_pkg::ST_ABSENT);

	// Only one transaction is in flight, so the input closes right after an accept.
	`MAC_ASSERT_NEXT(a_one_in_flight, in_fire, in_stall, "input accepted while a request is in work")

	// A fresh result only ever appears for an earlier accepted request.
	`MAC_ASSERT_NOW(a_result_latency, $rose(out_valid), $past(in_fire, 4), "result without matching request")

	// Releases never report allocatable bytes.
	`MAC_ASSERT_NOW(a_release_zero, out_valid && is_release, out_data.allocatable == '0, "release with bytes")

	// A stalled result stays in place.
	`MAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// A stalled request keeps its payload until it is taken.
	`MAC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled request changed")

endmodule

bind memory_admission_controller_top mac_checker u_mac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: tb/sv/memory_admission_controller_top_test.sv
// Self-checking testbench for the memory admission controller top level.
`timescale 1ns / 1ps

module memory_admission_controller_top_test;

	// Number of owner slots in the instance under test and the byte range of a request.
	localparam int SLOTS = mac_pkg::OWNER_SLOTS_DEF;
	localparam logic [mac_pkg::BYTES_W-1:0] BYTES_MAX = {mac_pkg::BYTES_W{1'b1}};

	// The watchdog ends the run once the cycles in a row without any transaction reach
	// this limit, which lies well beyond the reset sweep of the valid map and beyond any
	// plausible random streak of stalls at 82 percent.
	localparam int QUIET_LIMIT = 4000;

	// Cycles allowed after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	mac_pkg::in_item_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	mac_pkg::out_item_t            out_data;
	logic                          cfg_we    = 1'b0;
	logic [mac_pkg::BYTES_W-1:0]   cfg_wdata = '0;

	memory_admission_controller_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered to the block, and the verdicts that the accepted
	// requests are owed, oldest first.
	mac_pkg::in_item_t  request_backlog[$];
	mac_pkg::out_item_t awaited_verdicts[$];
	mac_pkg::out_item_t verdict_due;

	// Our own copy of the controller state: which owners hold a reservation, how many
	// bytes each holds, the running total and the safety margin as last written.
	bit                          slot_held  [SLOTS];
	logic [mac_pkg::BYTES_W-1:0] slot_bytes [SLOTS];
	logic [mac_pkg::TOTAL_W-1:0] reserved_sum = '0;
	logic [mac_pkg::BYTES_W-1:0] margin_q     = '0;

	// Idle rates of the current phase, in percent of cycles.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatches  = 0;
	int quiet_count = 0;

	// Works out the verdict for one accepted request and applies it to the state copy.
	function automatic mac_pkg::out_item_t judge_request(mac_pkg::in_item_t rq);
		mac_pkg::out_item_t          v;
		logic [mac_pkg::TOTAL_W-1:0] own;
		logic [mac_pkg::TOTAL_W-1:0] others;
		logic [mac_pkg::BYTES_W-1:0] headroom;
		v = '0;
		if (rq.op == mac_pkg::OP_RELEASE) begin
			if (int'(rq.owner_id) < SLOTS && slot_held[rq.owner_id]) begin
				reserved_sum = reserved_sum -
					mac_pkg::TOTAL_W'(slot_bytes[rq.owner_id]);
				slot_held[rq.owner_id] = 1'b0;
				v.status = mac_pkg::ST_RELEASED;
			end else begin
				v.status = mac_pkg::ST_ABSENT;
			end
		end else if (int'(rq.owner_id) >= SLOTS) begin
			// An owner with no slot is turned away without touching any state.
			v.status = mac_pkg::ST_REJECT;
		end else begin
			own = slot_held[rq.owner_id] ? mac_pkg::TOTAL_W'(slot_bytes[rq.owner_id]) : '0;
			others = reserved_sum - own;
			headroom = rq.free_bytes - margin_q;
			// Nothing is allocatable once the margin, or the margin plus the other
			// owners' reservations, reaches the available amount.
			if (margin_q >= rq.free_bytes || others >= mac_pkg::TOTAL_W'(headroom))
				v.allocatable = '0;
			else
				v.allocatable = headroom - others[mac_pkg::BYTES_W-1:0];
			if (rq.request_bytes > v.allocatable) begin
				// A rejected request leaves the owner's previous entry as it was.
				v.status = mac_pkg::ST_REJECT;
			end else begin
				reserved_sum = others + mac_pkg::TOTAL_W'(rq.request_bytes);
				slot_bytes[rq.owner_id] = rq.request_bytes;
				slot_held[rq.owner_id] = 1'b1;
				v.status = mac_pkg::ST_ADMIT;
			end
		end
		v.reserved_total = reserved_sum;
		return v;
	endfunction

	// A byte count spread evenly over its order of magnitude, so that small and huge
	// amounts are both common.
	function automatic logic [mac_pkg::BYTES_W-1:0] spread_bytes();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[mac_pkg::BYTES_W-1:0] >> $urandom_range(mac_pkg::BYTES_W - 1, 0);
	endfunction

	// One random request. Most requests go to a small pool of owners so that releases
	// and replacements hit live reservations; the rest go to the other owners with small
	// amounts, so that entries which are seldom released do not choke the total.
	function automatic mac_pkg::in_item_t random_request();
		mac_pkg::in_item_t rq;
		int                pick;
		rq.op = ($urandom_range(99) < 25) ? mac_pkg::OP_RELEASE : mac_pkg::OP_RESERVE;
		if ($urandom_range(99) < 85) begin
			rq.owner_id      = mac_pkg::OWNER_W'($urandom_range(15));
			rq.request_bytes = spread_bytes();
		end else begin
			rq.owner_id      = mac_pkg::OWNER_W'($urandom_range(255, 16));
			rq.request_bytes = spread_bytes() >> 24;
		end
		pick = $urandom_range(99);
		if (pick < 60)
			rq.free_bytes = 48'h0100_0000_0000 + (spread_bytes() >> 9);
		else if (pick < 80)
			rq.free_bytes = spread_bytes();
		else if (pick < 90)
			rq.free_bytes = BYTES_MAX;
		else
			rq.free_bytes = mac_pkg::BYTES_W'($urandom_range(255));
		return rq;
	endfunction

	task automatic queue_request(logic op, logic [mac_pkg::OWNER_W-1:0] owner,
			logic [mac_pkg::BYTES_W-1:0] req, logic [mac_pkg::BYTES_W-1:0] avail);
		mac_pkg::in_item_t rq;
		rq.op            = op;
		rq.owner_id      = owner;
		rq.request_bytes = req;
		rq.free_bytes    = avail;
		request_backlog.push_back(rq);
	endtask

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Writes the safety margin. It is only called while no request is in flight, so the
	// state copy can take the new value right away.
	task automatic write_margin(logic [mac_pkg::BYTES_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		margin_q   = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every queued request has been taken and every verdict has come back,
	// then lets the block run out its pipeline. Checks are made on the falling edge so
	// that they never race the clocked blocks.
	task automatic settle();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || in_valid || awaited_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Driver. A request is taken when valid is high and stall is low; the verdict is
	// predicted at that edge. A stalled transaction keeps its payload; otherwise the
	// next request is offered unless this cycle is chosen to be idle.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			awaited_verdicts.push_back(judge_request(in_data));
		if (!in_valid || !in_stall) begin
			if (arst_n && request_backlog.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_data  <= request_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor. Each result transaction is held against the oldest awaited verdict, field
	// by field. The stall toward the block is drawn anew every cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_verdicts.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: status %0d, alloc %h, total %h",
					out_data.status, out_data.allocatable, out_data.reserved_total));
			end else begin
				verdict_due = awaited_verdicts.pop_front();
				if (out_data.status !== verdict_due.status)
					flag_mismatch($sformatf("status expected %0d, got %0d",
						verdict_due.status, out_data.status));
				if (out_data.allocatable !== verdict_due.allocatable)
					flag_mismatch($sformatf("allocatable expected %h, got %h",
						verdict_due.allocatable, out_data.allocatable));
				if (out_data.reserved_total !== verdict_due.reserved_total)
					flag_mismatch($sformatf("reserved_total expected %h, got %h",
						verdict_due.reserved_total, out_data.reserved_total));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog. Any transaction on either channel, or a register write, restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus. A short directed part walks the corner cases under three margins, then
	// five random phases each run with the idle pattern and margin set for it.
	initial begin : stimulus
		int                          phase;
		int                          send_plan  [5];
		int                          stall_plan [5];
		logic [mac_pkg::BYTES_W-1:0] margin_plan[5];

		send_plan   = '{0, 82, 0, 22, 0};
		stall_plan  = '{0, 0, 82, 22, 0};
		margin_plan = '{spread_bytes(), 48'h0040_0000_0000, '0, 48'h0000_0010_0000, BYTES_MAX};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Margin zero. Release of an owner that holds nothing, a zero-byte reserve that
		// is admitted with nothing available, the full byte range for the top owner,
		// others' reservations that reach the available amount, replacement of an own
		// entry, a rejected request that keeps the old entry, and an exact fit.
		write_margin('0);
		queue_request(mac_pkg::OP_RELEASE, 8'd0, BYTES_MAX, '0);
		queue_request(mac_pkg::OP_RESERVE, 8'd0, '0, '0);
		queue_request(mac_pkg::OP_RELEASE, 8'd0, '0, BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd255, BYTES_MAX, BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd1, 48'd1, BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd255, 48'd1, 48'd2);
		queue_request(mac_pkg::OP_RESERVE, 8'd255, 48'd3, 48'd2);
		queue_request(mac_pkg::OP_RELEASE, 8'd255, '0, '0);
		queue_request(mac_pkg::OP_RESERVE, 8'd128, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
		queue_request(mac_pkg::OP_RESERVE, 8'd127, 48'hAAAA_AAAA_AAAA, BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd127, 48'd1, BYTES_MAX);
		queue_request(mac_pkg::OP_RELEASE, 8'd127, '0, '0);
		queue_request(mac_pkg::OP_RELEASE, 8'd128, '0, '0);
		queue_request(mac_pkg::OP_RELEASE, 8'd200, '0, '0);
		settle();

		// Largest margin: it swallows everything, so only a zero-byte reserve gets in.
		write_margin(BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd3, '0, BYTES_MAX);
		queue_request(mac_pkg::OP_RESERVE, 8'd3, 48'd1, BYTES_MAX);
		queue_request(mac_pkg::OP_RELEASE, 8'd3, '0, '0);
		settle();

		// A small margin right at the edges: margin equal to available, one byte of room,
		// and another owner's byte filling that room.
		write_margin(48'd100);
		queue_request(mac_pkg::OP_RESERVE, 8'd4, '0, 48'd100);
		queue_request(mac_pkg::OP_RESERVE, 8'd4, 48'd1, 48'd101);
		queue_request(mac_pkg::OP_RESERVE, 8'd5, 48'd1, 48'd101);
		queue_request(mac_pkg::OP_RELEASE, 8'd4, '0, '0);
		settle();

		for (phase = 0; phase < 5; phase++) begin
			send_idle_pct  = send_plan[phase];
			recv_stall_pct = stall_plan[phase];
			write_margin(margin_plan[phase]);
			repeat (140) request_backlog.push_back(random_request());
			settle();
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
